/* src/fopm_pkg.sv */
// ----------------------------------------------------------------------------
// fopm_pkg: shared types and fp32 arithmetic for the outer product tile
// single precision multiply and add, round to nearest even, flush to zero,
// default nan on every invalid result
// ----------------------------------------------------------------------------
package fopm_pkg;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // per-cycle controls broadcast to every cell
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic rot_en;
  } fopm_ctrl_t;

  function automatic logic [31:0] flush_in(input logic [31:0] u);
    if (u[30:23] == 8'd0) return {u[31], 31'd0};
    return u;
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]       x;
    logic [31:0]       y;
    logic              s;
    logic              xz;
    logic              yz;
    logic [47:0]       p;
    logic [22:0]       m;
    logic              g;
    logic              st;
    logic signed [9:0] e;
    logic [24:0]       mr;
    x  = flush_in(a);
    y  = flush_in(b);
    s  = x[31] ^ y[31];
    xz = (x[30:0] == 31'd0);
    yz = (y[30:0] == 31'd0);
    if (fp_is_nan(x) || fp_is_nan(y) || (fp_is_inf(x) && yz) || (fp_is_inf(y) && xz))
      return QNAN;
    if (fp_is_inf(x) || fp_is_inf(y)) return {s, 8'hFF, 23'd0};
    if (xz || yz) return {s, 31'd0};
    p = {1'b1, x[22:0]} * {1'b1, y[22:0]};
    e = $signed({2'b00, x[30:23]}) + $signed({2'b00, y[30:23]}) - 10'sd127;
    if (p[47]) begin
      m  = p[46:24];
      g  = p[23];
      st = |p[22:0];
      e  = e + 10'sd1;
    end else begin
      m  = p[45:23];
      g  = p[22];
      st = |p[21:0];
    end
    // tiny before rounding flushes to signed zero
    if (e <= 10'sd0) return {s, 31'd0};
    mr = {2'b01, m} + 25'(g & (st | m[0]));
    if (mr[24]) begin
      e = e + 10'sd1;
      m = 23'd0;
    end else begin
      m = mr[22:0];
    end
    if (e >= 10'sd255) return {s, 8'hFF, 23'd0};
    return {s, e[7:0], m};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       t;
    logic [7:0]        d;
    logic [27:0]       mx;
    logic [27:0]       my;
    logic [27:0]       sh;
    logic [27:0]       sum;
    logic              stk;
    logic [4:0]        lz;
    logic              found;
    logic signed [9:0] e;
    logic [22:0]       m;
    logic [24:0]       mr;
    x = flush_in(a);
    y = flush_in(b);
    if (fp_is_nan(x) || fp_is_nan(y)) return QNAN;
    if (fp_is_inf(x) && fp_is_inf(y) && (x[31] != y[31])) return QNAN;
    if (fp_is_inf(x)) return x;
    if (fp_is_inf(y)) return y;
    if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) return {x[31] & y[31], 31'd0};
    if (x[30:0] == 31'd0) return y;
    if (y[30:0] == 31'd0) return x;
    // larger magnitude first
    if (y[30:0] > x[30:0]) begin
      t = x;
      x = y;
      y = t;
    end
    d  = x[30:23] - y[30:23];
    mx = {1'b0, 1'b1, x[22:0], 3'b000};
    my = {1'b0, 1'b1, y[22:0], 3'b000};
    if (d >= 8'd28) begin
      sh  = 28'd0;
      stk = 1'b1;
    end else begin
      sh  = my >> d;
      stk = |(my & ((28'd1 << d) - 28'd1));
    end
    sh[0] = sh[0] | stk;
    e = $signed({2'b00, x[30:23]});
    if (x[31] == y[31]) begin
      sum = mx + sh;
    end else begin
      sum = mx - sh;
    end
    if (sum == 28'd0) return 32'd0;
    if (sum[27]) begin
      sum = {1'b0, sum[27:2], sum[1] | sum[0]};
      e   = e + 10'sd1;
    end else begin
      lz    = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && sum[i]) begin
          found = 1'b1;
          lz    = 5'(26 - i);
        end
      end
      sum = sum << lz;
      e   = e - $signed({5'd0, lz});
    end
    if (e <= 10'sd0) return {x[31], 31'd0};
    m  = sum[25:3];
    mr = {2'b01, m} + 25'(sum[2] & (sum[1] | sum[0] | m[0]));
    if (mr[24]) begin
      e = e + 10'sd1;
      m = 23'd0;
    end else begin
      m = mr[22:0];
    end
    if (e >= 10'sd255) return {x[31], 8'hFF, 23'd0};
    return {x[31], e[7:0], m};
  endfunction

endpackage

/* src/fp32_outer_product_mac_tile.sv */
// ----------------------------------------------------------------------------
// fp32_outer_product_mac_tile: fp32 outer product accumulator tile
// a TILE_ROWS x TILE_COLS grid of multiply-accumulate cells for gemm kernels
// ----------------------------------------------------------------------------
// channel   dir  tuser     tlast      tdata
// s_axis    in   req_type  last_step  row_sel, a_pair0..2, b_pair0..3
// m_axis    out  -         row_last   out_row, sum_pair0..3
//
// a load request writes its row as it is taken; a step request goes through
// multiply into the product register, add into the accumulator, back to idle
// a step marked last then rotates the rows up the cell chain TILE_ROWS times,
// sending row 0 each cycle for the first NROWS rotations; a stalled output holds the rotation
// reset clears every accumulator to +0.0 and empties the output register
// ----------------------------------------------------------------------------
module fp32_outer_product_mac_tile #(
  parameter int TILE_ROWS = 6,
  parameter int TILE_COLS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [455:0] s_axis_tdata,  // row_sel, a_pair0, a_pair1, a_pair2, b_pair0..3, zero pad
  input  logic         s_axis_tuser,  // req_type
  input  logic         s_axis_tlast,  // last_step
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata,  // out_row, sum_pair0..3, zero pad
  output logic         m_axis_tlast   // row_last
);
  import fopm_pkg::*;

  localparam int NROWS = (TILE_ROWS < 6) ? TILE_ROWS : 6;
  localparam int NCOLS = (TILE_COLS < 8) ? TILE_COLS : 8;
  localparam int RW    = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_EMIT} state_e;

  state_e      state_q;
  logic        last_q;
  logic [RW-1:0] rot_q;
  logic        out_valid_q;
  logic [2:0]  out_row_q;
  logic        out_last_q;
  logic [255:0] out_sum_q;

  logic         in_acc;
  logic [2:0]   row_sel;
  logic [191:0] a_all;
  logic [255:0] b_all;
  logic         emit_row;
  logic         rot_go;
  fopm_ctrl_t   ctrl;
  logic [255:0] row0_sum;

  logic [31:0] acc [TILE_ROWS][TILE_COLS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign row_sel       = s_axis_tdata[2:0];
  assign a_all         = s_axis_tdata[194:3];
  assign b_all         = s_axis_tdata[450:195];

  // rows past the emitted ones rotate without an output slot
  assign emit_row = (int'(rot_q) < NROWS);
  assign rot_go   = (state_q == ST_EMIT) && (!emit_row || !out_valid_q || m_axis_tready);

  assign ctrl.mul_en = in_acc && s_axis_tuser;
  assign ctrl.add_en = (state_q == ST_MUL);
  assign ctrl.rot_en = rot_go;

  // cell grid; each row hands its accumulators to the row above when rotating
  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    logic        load_en;
    logic [31:0] a_val;
    assign load_en = in_acc && !s_axis_tuser && (int'(row_sel) == r);
    if (r < 6) begin : g_a
      assign a_val = a_all[32*r +: 32];
    end else begin : g_a0
      assign a_val = 32'd0;
    end
    for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
      logic [31:0] b_val;
      logic        ld;
      if (c < 8) begin : g_b
        assign b_val = b_all[32*c +: 32];
        assign ld    = load_en;
      end else begin : g_b0
        assign b_val = 32'd0;
        assign ld    = 1'b0;
      end
      fopm_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .load_en_i  (ld),
        .load_val_i (b_val),
        .a_i        (a_val),
        .b_i        (b_val),
        .rot_i      (acc[(r + 1) % TILE_ROWS][c]),
        .acc_o      (acc[r][c])
      );
    end
  end

  always_comb begin
    row0_sum = '0;
    for (int c = 0; c < NCOLS; c++) begin
      row0_sum[32*c +: 32] = acc[0][c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new row takes the output slot as the old one leaves
      if (rot_go && emit_row) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            last_q  <= s_axis_tlast;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          rot_q   <= '0;
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (rot_go) begin
            if (int'(rot_q) == TILE_ROWS - 1) begin
              state_q <= ST_IDLE;
            end else begin
              rot_q <= rot_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (rot_go && emit_row) begin
      out_row_q  <= 3'(rot_q);
      out_last_q <= (int'(rot_q) == NROWS - 1);
      out_sum_q  <= row0_sum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_sum_q, out_row_q};

endmodule

/* src/fopm_cell.sv */
// ----------------------------------------------------------------------------
// fopm_cell: one accumulator of the tile
// registered product, then accumulate; hands its value to the row above
// ----------------------------------------------------------------------------
module fopm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fopm_pkg::fopm_ctrl_t ctrl_i,
  input  logic              load_en_i,
  input  logic [31:0]       load_val_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [31:0]       rot_i,
  output logic [31:0]       acc_o
);
  import fopm_pkg::*;

  logic [31:0] prod_q;
  logic [31:0] acc_q;
  logic [31:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    if (load_en_i) begin
      acc_d = load_val_i;
    end else if (ctrl_i.rot_en) begin
      acc_d = rot_i;
    end else if (ctrl_i.add_en) begin
      acc_d = fp_add(acc_q, prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 32'd0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= fp_mul(a_i, b_i);
    end
  end

  assign acc_o = acc_q;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fp32 outer product accumulator tile
// random and directed load and step requests with random stalls on both sides;
// a scoreboard keeps its own copy of the accumulators and checks every row
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ROWS = 6;
  localparam int COLS = 8;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;
  localparam logic [31:0] DEF_NAN = 32'h7FC0_0000;

  // one input request as it travels on the slave side
  typedef struct {
    logic        req_type;
    logic [2:0]  row_sel;
    logic [63:0] a_pair [3];
    logic [63:0] b_pair [4];
    logic        last_step;
  } tile_req_t;

  // one emitted accumulator row
  typedef struct {
    logic [2:0]  out_row;
    logic [63:0] sum_pair [4];
    logic        row_last;
  } tile_row_t;

  // --------------------------------------------------------------------------
  // scoreboard: fp32 accumulator model and queue of expected rows
  // --------------------------------------------------------------------------
  class tile_scoreboard;
    logic [31:0] acc [ROWS][COLS];
    tile_row_t   rows_due [$];
    int          errors;

    function new();
      errors = 0;
      foreach (acc[r, c]) acc[r][c] = 32'd0;
    endfunction

    function logic [31:0] ftz(logic [31:0] u);
      if (u[30:23] == 8'd0) return {u[31], 31'd0};
      return u;
    endfunction

    function logic is_nan(logic [31:0] u);
      return u[30:23] == 8'hFF && u[22:0] != 0;
    endfunction

    function logic is_inf(logic [31:0] u);
      return u[30:23] == 8'hFF && u[22:0] == 0;
    endfunction

    // value is (mant / 2^63) * 2^(exp - 127); round to nearest even, flush tiny
    function logic [31:0] round_pack(logic s, int exp, logic [63:0] mant);
      logic [22:0] frac;
      logic [23:0] rnd;
      if (mant == 0) return 32'd0;
      while (!mant[63]) begin
        mant = mant << 1;
        exp--;
      end
      if (exp <= 0) return {s, 31'd0};
      frac = mant[62:40];
      rnd  = {1'b0, frac} + 24'(mant[39] & ((|mant[38:0]) | frac[0]));
      if (rnd[23]) begin
        exp++;
        frac = 23'd0;
      end else begin
        frac = rnd[22:0];
      end
      if (exp >= 255) return {s, 8'hFF, 23'd0};
      return {s, exp[7:0], frac};
    endfunction

    function logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic [31:0] x, y;
      logic        s, xz, yz;
      logic [47:0] p;
      x  = ftz(a);
      y  = ftz(b);
      s  = x[31] ^ y[31];
      xz = x[30:0] == 0;
      yz = y[30:0] == 0;
      if (is_nan(x) || is_nan(y) || (is_inf(x) && yz) || (is_inf(y) && xz)) return DEF_NAN;
      if (is_inf(x) || is_inf(y)) return {s, 8'hFF, 23'd0};
      if (xz || yz) return {s, 31'd0};
      p = {1'b1, x[22:0]} * {1'b1, y[22:0]};
      return round_pack(s, int'(x[30:23]) + int'(y[30:23]) - 126, {p, 16'd0});
    endfunction

    function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
      logic [31:0] x, y, t;
      logic [63:0] mx, my, sh, sum;
      int          d;
      x = ftz(a);
      y = ftz(b);
      if (is_nan(x) || is_nan(y)) return DEF_NAN;
      if (is_inf(x) && is_inf(y) && x[31] != y[31]) return DEF_NAN;
      if (is_inf(x)) return x;
      if (is_inf(y)) return y;
      if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
      if (x[30:0] == 0) return y;
      if (y[30:0] == 0) return x;
      if (y[30:0] > x[30:0]) begin
        t = x;
        x = y;
        y = t;
      end
      d  = int'(x[30:23]) - int'(y[30:23]);
      mx = {2'b01, x[22:0], 39'd0};
      my = {2'b01, y[22:0], 39'd0};
      // bits shifted out collapse into a sticky lsb
      if (d >= 64) begin
        sh = 64'd1;
      end else begin
        sh    = my >> d;
        sh[0] = sh[0] | (|(my & ((64'd1 << d) - 64'd1)));
      end
      sum = (x[31] == y[31]) ? mx + sh : mx - sh;
      return round_pack(x[31], int'(x[30:23]) + 1, sum);
    endfunction

    // note an accepted request and queue the rows it causes
    function void note_request(tile_req_t q);
      logic [31:0] av, bv;
      tile_row_t   row;
      if (q.req_type == REQ_LOAD) begin
        if (q.row_sel < ROWS)
          for (int c = 0; c < COLS; c++) acc[q.row_sel][c] = q.b_pair[c / 2][32 * (c % 2) +: 32];
        return;
      end
      for (int r = 0; r < ROWS; r++) begin
        av = q.a_pair[r / 2][32 * (r % 2) +: 32];
        for (int c = 0; c < COLS; c++) begin
          bv = q.b_pair[c / 2][32 * (c % 2) +: 32];
          acc[r][c] = add32(acc[r][c], mul32(av, bv));
        end
      end
      if (!q.last_step) return;
      for (int r = 0; r < ROWS; r++) begin
        row.out_row = 3'(r);
        for (int j = 0; j < 4; j++) row.sum_pair[j] = {acc[r][2 * j + 1], acc[r][2 * j]};
        row.row_last = (r == ROWS - 1);
        rows_due.push_back(row);
      end
    endfunction

    // compare an emitted row with the oldest expected one
    function void check_row(tile_row_t got);
      tile_row_t want;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected row %0d", $realtime, got.out_row);
        return;
      end
      want = rows_due.pop_front();
      if (got.out_row !== want.out_row) begin
        errors++;
        $display("%0t: out_row expected %0d actual %0d", $realtime, want.out_row, got.out_row);
      end
      for (int j = 0; j < 4; j++)
        if (got.sum_pair[j] !== want.sum_pair[j]) begin
          errors++;
          $display("%0t: row %0d sum_pair%0d expected %h actual %h", $realtime,
                   want.out_row, j, want.sum_pair[j], got.sum_pair[j]);
        end
      if (got.row_last !== want.row_last) begin
        errors++;
        $display("%0t: row_last expected %0b actual %0b", $realtime, want.row_last, got.row_last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [455:0] s_axis_tdata = '0;  // row_sel, a_pair0..2, b_pair0..3, zero pad
  logic         s_axis_tuser = 1'b0;  // req_type
  logic         s_axis_tlast = 1'b0;  // last_step
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;  // out_row, sum_pair0..3, zero pad
  logic         m_axis_tlast;  // row_last

  tile_scoreboard sb = new();
  int  hold_cycles = 0;  // long receiver hold-off, counted by the receiver
  bit  stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  fp32_outer_product_mac_tile u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly moderate exponents so sums stay finite, plus every special class
  function automatic logic [31:0] pick_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;                                         // any bit pattern
      2:    v[30:23] = 8'd0;                          // zero or subnormal
      3:    v[30:23] = 8'hFF;                         // inf or nan
      4:    v[30:23] = 8'($urandom_range(1, 40));     // tiny products
      5:    v[30:23] = 8'($urandom_range(200, 254));  // overflow
      default: v[30:23] = 8'($urandom_range(112, 142));
    endcase
    return v;
  endfunction

  function automatic tile_req_t rand_req(logic rt, logic last);
    tile_req_t q;
    q.req_type  = rt;
    q.row_sel   = 3'($urandom_range(0, 7));
    q.last_step = last;
    for (int i = 0; i < 3; i++) q.a_pair[i] = {pick_fp(), pick_fp()};
    for (int i = 0; i < 4; i++) q.b_pair[i] = {pick_fp(), pick_fp()};
    return q;
  endfunction

  function automatic tile_req_t fill_req(logic rt, logic [2:0] row, logic [31:0] av,
                                         logic [31:0] bv, logic last);
    tile_req_t q;
    q.req_type  = rt;
    q.row_sel   = row;
    q.last_step = last;
    for (int i = 0; i < 3; i++) q.a_pair[i] = {av, av};
    for (int i = 0; i < 4; i++) q.b_pair[i] = {bv, bv};
    return q;
  endfunction

  // offer one request after a random gap and wait for the handshake
  task automatic send_req(tile_req_t q);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {5'd0, q.b_pair[3], q.b_pair[2], q.b_pair[1], q.b_pair[0],
                     q.a_pair[2], q.a_pair[1], q.a_pair[0], q.row_sel};
    s_axis_tuser  = q.req_type;
    s_axis_tlast  = q.last_step;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(q);
    @(negedge clk_i);
  endtask

  task automatic drain_rows();
    s_axis_tvalid = 1'b0;
    while (sb.rows_due.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls per row, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int wait_cyc;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        while (hold_cycles > 0) begin
          @(negedge clk_i);
          hold_cycles--;
        end
      end
      wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      m_axis_tready = 1'b0;
      repeat (wait_cyc) @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // row monitor
  always @(posedge clk_i) begin
    tile_row_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_row = m_axis_tdata[2:0];
      for (int j = 0; j < 4; j++) got.sum_pair[j] = m_axis_tdata[3 + 64 * j +: 64];
      got.row_last = m_axis_tlast;
      sb.check_row(got);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    tile_req_t q;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty tile emission, loads of specials, ignored rows, specials
    send_req(fill_req(REQ_STEP, 3'd0, 32'h0000_0000, 32'h8000_0000, 1'b1));
    send_req(fill_req(REQ_LOAD, 3'd0, 32'h0, 32'h0000_0001, 1'b1));  // subnormal kept
    send_req(fill_req(REQ_LOAD, 3'd1, 32'h0, 32'h7F80_0000, 1'b0));
    send_req(fill_req(REQ_LOAD, 3'd2, 32'h0, 32'hFF7F_FFFF, 1'b0));
    send_req(fill_req(REQ_LOAD, 3'd3, 32'h0, 32'h7FFF_FFFF, 1'b0));
    send_req(fill_req(REQ_LOAD, 3'd4, 32'h0, 32'h8000_0000, 1'b0));
    send_req(fill_req(REQ_LOAD, 3'd5, 32'h0, 32'h3F80_0000, 1'b0));
    send_req(fill_req(REQ_LOAD, 3'd6, 32'h0, 32'h4000_0000, 1'b1));  // ignored
    send_req(fill_req(REQ_LOAD, 3'd7, 32'h0, 32'h4000_0000, 1'b0));  // ignored
    send_req(fill_req(REQ_STEP, 3'd0, 32'h3F80_0000, 32'h3F80_0000, 1'b1));
    send_req(fill_req(REQ_STEP, 3'd0, 32'h7F80_0000, 32'h0000_0000, 1'b0));  // inf times zero
    send_req(fill_req(REQ_STEP, 3'd0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0));  // overflow
    send_req(fill_req(REQ_STEP, 3'd0, 32'h0080_0000, 32'h3F00_0000, 1'b0));  // tiny product
    send_req(fill_req(REQ_STEP, 3'd0, 32'h007F_FFFF, 32'h3F80_0000, 1'b1));  // subnormal input
    for (int r = 0; r < ROWS; r++)
      send_req(fill_req(REQ_LOAD, 3'(r), 32'h0, 32'h3F80_0000, 1'b0));
    send_req(fill_req(REQ_STEP, 3'd0, 32'hBF80_0000, 32'h3F80_0000, 1'b1));  // exact cancel
    send_req(fill_req(REQ_STEP, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

    // random part: mostly steps with occasional loads and last markers
    for (int n = 0; n < 138; n++) begin
      if (n == 60) begin
        // sender waits for the tile to empty its output
        drain_rows();
      end
      if (n == 90) hold_cycles = 150;  // receiver holds off while steps keep coming
      if (n >= 90 && n < 100) q = rand_req(REQ_STEP, 1'b1);
      else if ($urandom_range(0, 3) == 0) q = rand_req(REQ_LOAD, 1'($urandom_range(0, 1)));
      else q = rand_req(REQ_STEP, $urandom_range(0, 6) == 0);
      send_req(q);
    end
    send_req(rand_req(REQ_STEP, 1'b1));

    drain_rows();
    repeat (30) @(negedge clk_i);
    if (sb.errors == 0 && sb.rows_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
